// ===== rtl/core/lmq_pkg.sv =====
// Shared types, constants and the font table of the LED marquee scroller.
package lmq_pkg;

  localparam int GLYPH_ROWS  = 5;
  localparam int GLYPH_COLS  = 6;
  localparam int GLYPH_W     = 5;
  localparam int GLYPH_IDX_W = 5;
  localparam int WRAP_W      = 6;
  localparam int ROW_IDX_W   = 3;
  localparam int OUT_PIX_W   = 48;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_FROM_NEXT,
    CELL_FROM_PREV
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [GLYPH_IDX_W-1:0]   glyph;
    logic [2:0]               slot;
    logic [WRAP_W-1:0]        wrap;
  } cell_cmd_t;

  // All five rows of a glyph, row 0 in the lowest bits; bit 0 of a row is its left column.
  function automatic logic [GLYPH_ROWS*GLYPH_W-1:0] font_glyph(
    input logic [GLYPH_IDX_W-1:0] g
  );
    logic [GLYPH_ROWS*GLYPH_W-1:0] f;
    case (g)
      5'd0:    f = '0;
      5'd1:    f = {5'b01100, 5'b00000, 5'b01100, 5'b01100, 5'b01100};
      5'd2:    f = {5'b10001, 5'b10001, 5'b11111, 5'b01010, 5'b00100};
      5'd3:    f = {5'b11111, 5'b10001, 5'b11111, 5'b10001, 5'b11111};
      5'd4:    f = {5'b11111, 5'b00001, 5'b00001, 5'b00001, 5'b11111};
      5'd5:    f = {5'b01111, 5'b10001, 5'b10001, 5'b10001, 5'b01111};
      5'd6:    f = {5'b11111, 5'b00001, 5'b11111, 5'b00001, 5'b11111};
      5'd7:    f = {5'b00001, 5'b00001, 5'b11111, 5'b00001, 5'b11111};
      5'd8:    f = {5'b11111, 5'b10001, 5'b11101, 5'b00001, 5'b11111};
      5'd9:    f = {5'b10001, 5'b10001, 5'b11111, 5'b10001, 5'b10001};
      5'd10:   f = {5'b11111, 5'b00100, 5'b00100, 5'b00100, 5'b11111};
      5'd11:   f = {5'b00111, 5'b00100, 5'b00100, 5'b00100, 5'b11111};
      5'd12:   f = {5'b10001, 5'b01001, 5'b00111, 5'b01001, 5'b10001};
      5'd13:   f = {5'b11111, 5'b00001, 5'b00001, 5'b00001, 5'b00001};
      5'd14:   f = {5'b10001, 5'b10001, 5'b10101, 5'b11011, 5'b10001};
      5'd15:   f = {5'b10001, 5'b11001, 5'b10101, 5'b10011, 5'b10001};
      5'd16:   f = {5'b11111, 5'b10001, 5'b10001, 5'b10001, 5'b11111};
      5'd17:   f = {5'b00001, 5'b00001, 5'b11111, 5'b10001, 5'b11111};
      5'd18:   f = {5'b01000, 5'b11111, 5'b10101, 5'b10001, 5'b11111};
      5'd19:   f = {5'b10001, 5'b01001, 5'b11111, 5'b10001, 5'b11111};
      5'd20:   f = {5'b11111, 5'b10000, 5'b11111, 5'b00001, 5'b11111};
      5'd21:   f = {5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b11111};
      5'd22:   f = {5'b11111, 5'b10001, 5'b10001, 5'b10001, 5'b10001};
      5'd23:   f = {5'b00100, 5'b01010, 5'b01010, 5'b10001, 5'b10001};
      5'd24:   f = {5'b10001, 5'b11011, 5'b10101, 5'b10001, 5'b10001};
      5'd25:   f = {5'b10001, 5'b01010, 5'b00100, 5'b01010, 5'b10001};
      5'd26:   f = {5'b00100, 5'b00100, 5'b00100, 5'b01010, 5'b10001};
      5'd27:   f = {5'b11111, 5'b00010, 5'b00100, 5'b01000, 5'b11111};
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/lmq_cell.sv =====
// One board row of the marquee: loads glyph columns, rotates horizontally or takes a neighbor row.
module lmq_cell import lmq_pkg::*; #(
  parameter int ROW_W   = 48,
  parameter int ROW_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_cmd_t        cmd,
  input  logic [ROW_W-1:0] next_row,
  input  logic [ROW_W-1:0] prev_row,
  output logic [ROW_W-1:0] row
);

  logic [ROW_W-1:0]                row_r;
  logic [ROW_W-1:0]                row_nxt;
  logic [ROW_W-1:0]                left_v;
  logic [ROW_W-1:0]                right_v;
  logic [ROW_W-1:0]                load_v;
  logic [GLYPH_ROWS*GLYPH_W-1:0]   glyph_all;
  logic [GLYPH_W-1:0]              grow;
  logic                            wrap_bit;

  assign glyph_all = font_glyph(cmd.glyph);
  assign grow      = glyph_all[ROW_IDX*GLYPH_W +: GLYPH_W];

  // Bit at the wrap point, which a right rotation moves to column 0.
  always_comb begin
    wrap_bit = 1'b0;
    for (int c = 0; c < ROW_W; c++) begin
      if (WRAP_W'(c) == cmd.wrap - WRAP_W'(1)) begin
        wrap_bit = row_r[c];
      end
    end
  end

  for (genvar c = 0; c < ROW_W; c++) begin : g_col
    localparam int CHR = c / GLYPH_COLS;
    localparam int COL = c % GLYPH_COLS;
    logic in_w;
    assign in_w = WRAP_W'(c) < cmd.wrap;

    if (c < ROW_W - 1) begin : g_left
      assign left_v[c] = !in_w ? row_r[c] :
                         (WRAP_W'(c) == cmd.wrap - WRAP_W'(1)) ? row_r[0] : row_r[c+1];
    end else begin : g_left_end
      assign left_v[c] = in_w ? row_r[0] : row_r[c];
    end

    if (c == 0) begin : g_right
      assign right_v[c] = wrap_bit;
    end else begin : g_right_mid
      assign right_v[c] = in_w ? row_r[c-1] : row_r[c];
    end

    if (COL < GLYPH_W) begin : g_load
      assign load_v[c] = ({1'b0, cmd.slot} == 4'(CHR)) ? grow[COL] : row_r[c];
    end else begin : g_load_dark
      assign load_v[c] = ({1'b0, cmd.slot} == 4'(CHR)) ? 1'b0 : row_r[c];
    end
  end

  always_comb begin
    case (cmd.op)
      CELL_HOLD:      row_nxt = row_r;
      CELL_LOAD:      row_nxt = load_v;
      CELL_LEFT:      row_nxt = left_v;
      CELL_RIGHT:     row_nxt = right_v;
      CELL_FROM_NEXT: row_nxt = next_row;
      CELL_FROM_PREV: row_nxt = prev_row;
      default:        row_nxt = row_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row = row_r;

endmodule

// ===== rtl/core/led_marquee_scroller.sv =====
// Top level of the LED marquee scroller: command decode, row chain and result register.
//
// The input stream carries one command per transaction. in_tuser selects a glyph
// load (0) or a shift (1). A load writes the glyph of char_code into a character
// slot and returns one transaction with bad_char on out_tuser when the character
// has no glyph. A shift rotates the board one pixel in the given direction and
// returns five transactions, rows 0 to 4, out_tlast set on row 4.
// The board lives in a chain of five row cells. Results are read from the head
// cell while the chain rotates by one row per emitted transaction, so the board
// is back in place after the fifth row.
// A load result appears the cycle after acceptance. A shift is applied on
// acceptance and its five rows are then emitted from ST_EMIT. in_tready
// stays low during emission. A single output register holds each result; a
// stall on out_tready freezes the chain until the result is taken.
// cfg_wr_en writes message_length, which sets the horizontal wrap at six columns
// per character. Reset clears the board, empties the output register and sets
// message_length to 8.
module led_marquee_scroller import lmq_pkg::*; #(
  parameter int MAX_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // slot[2:0], char_code[9:3], direction[11:10], zero pad
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // row_index[2:0], row_pixels[50:3], zero pad
  output logic        out_tlast,  // last_row
  output logic        out_tuser   // bad_char
);

  localparam int ROW_W = GLYPH_COLS * MAX_CHARS;

  localparam logic       OP_LOAD    = 1'b0;
  localparam logic [1:0] DIR_LEFT   = 2'd0;
  localparam logic [1:0] DIR_RIGHT  = 2'd1;
  localparam logic [1:0] DIR_UP     = 2'd2;
  localparam logic [1:0] DIR_DOWN   = 2'd3;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t                  state_r;
  logic [ROW_IDX_W-1:0]    cnt_r;
  logic [3:0]              len_r;
  logic                    out_valid_r;
  logic [ROW_IDX_W-1:0]    out_idx_r;
  logic [OUT_PIX_W-1:0]    out_pix_r;
  logic                    out_last_r;
  logic                    out_bad_r;

  logic [2:0]              in_slot;
  logic [6:0]              in_char;
  logic [1:0]              in_dir;
  logic                    in_acc;
  logic                    out_free;
  logic                    out_fill;
  logic [3:0]              len_eff;
  logic [WRAP_W-1:0]       wrap;
  logic                    glyph_ok;
  logic [GLYPH_IDX_W-1:0]  glyph_idx;
  logic                    slot_ok;
  cell_cmd_t               cmd;
  logic [ROW_W-1:0]        rows [GLYPH_ROWS];
  logic [OUT_PIX_W-1:0]    head_pix;

  assign in_slot  = in_tdata[2:0];
  assign in_char  = in_tdata[9:3];
  assign in_dir   = in_tdata[11:10];
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc   = in_tvalid && in_tready;
  assign slot_ok  = {1'b0, in_slot} < 4'(MAX_CHARS);
  // The output register takes a new result in this cycle.
  assign out_fill = (in_acc && in_tuser == OP_LOAD) || (state_r == ST_EMIT && out_free);

  // Out-of-range lengths clamp to one and to the slot count.
  always_comb begin
    if (len_r == 4'd0) begin
      len_eff = 4'd1;
    end else if (len_r > 4'(MAX_CHARS)) begin
      len_eff = 4'(MAX_CHARS);
    end else begin
      len_eff = len_r;
    end
    wrap = WRAP_W'(len_eff) * WRAP_W'(GLYPH_COLS);
  end

  always_comb begin
    glyph_ok  = 1'b1;
    glyph_idx = '0;
    if (in_char == 7'd32) begin
      glyph_idx = 5'd0;
    end else if (in_char == 7'd33) begin
      glyph_idx = 5'd1;
    end else if (in_char >= 7'd65 && in_char <= 7'd90) begin
      glyph_idx = 5'(in_char - 7'd63);
    end else if (in_char >= 7'd97 && in_char <= 7'd122) begin
      glyph_idx = 5'(in_char - 7'd95);
    end else begin
      glyph_ok = 1'b0;
    end
  end

  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.glyph = glyph_idx;
    cmd.slot  = in_slot;
    cmd.wrap  = wrap;
    if (in_acc) begin
      if (in_tuser == OP_LOAD) begin
        if (glyph_ok && slot_ok) begin
          cmd.op = CELL_LOAD;
        end
      end else begin
        case (in_dir)
          DIR_LEFT:  cmd.op = CELL_LEFT;
          DIR_RIGHT: cmd.op = CELL_RIGHT;
          DIR_UP:    cmd.op = CELL_FROM_NEXT;
          DIR_DOWN:  cmd.op = CELL_FROM_PREV;
          default:   cmd.op = CELL_HOLD;
        endcase
      end
    end else if (state_r == ST_EMIT && out_free) begin
      cmd.op = CELL_FROM_NEXT;
    end
  end

  for (genvar i = 0; i < GLYPH_ROWS; i++) begin : g_cell
    lmq_cell #(
      .ROW_W   (ROW_W),
      .ROW_IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .next_row (rows[(i + 1) % GLYPH_ROWS]),
      .prev_row (rows[(i + GLYPH_ROWS - 1) % GLYPH_ROWS]),
      .row      (rows[i])
    );
  end

  // Head row masked to the wrap width, fitted to the result field.
  for (genvar b = 0; b < OUT_PIX_W; b++) begin : g_pix
    if (b < ROW_W) begin : g_in
      assign head_pix[b] = rows[0][b] && (WRAP_W'(b) < wrap);
    end else begin : g_out
      assign head_pix[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      len_r       <= 4'd8;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      if (out_valid_r && out_tready && !out_fill) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser == OP_LOAD) begin
              out_valid_r <= 1'b1;
              out_idx_r   <= '0;
              out_pix_r   <= '0;
              out_last_r  <= 1'b1;
              out_bad_r   <= !glyph_ok;
            end else begin
              state_r <= ST_EMIT;
              cnt_r   <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= cnt_r;
            out_pix_r   <= head_pix;
            out_last_r  <= (cnt_r == ROW_IDX_W'(GLYPH_ROWS - 1));
            out_bad_r   <= 1'b0;
            if (cnt_r == ROW_IDX_W'(GLYPH_ROWS - 1)) begin
              state_r <= ST_IDLE;
              cnt_r   <= '0;
            end else begin
              cnt_r <= cnt_r + ROW_IDX_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_pix_r, out_idx_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == OP_LOAD) |=> (out_valid_r && out_last_r && out_idx_r == '0))
    else $error("load transaction did not produce a single last result");

  a_shift_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser != OP_LOAD) |=> (state_r == ST_EMIT && cnt_r == '0))
    else $error("shift transaction did not start row emission");

  a_bad_only_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_last_r && out_idx_r == '0 && out_pix_r == '0))
    else $error("bad character flag on a frame row");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r < ROW_IDX_W'(GLYPH_ROWS) && !in_tready))
    else $error("row counter out of range or input open during emission");

endmodule

// ===== verif/marquee_tb_pkg.sv =====
// Command codes and the expected-row type shared by the marquee testbench files.
`timescale 1ns / 1ps
package marquee_tb_pkg;

  typedef enum logic {
    OP_LOAD,
    OP_SHIFT
  } marquee_op_t;

  typedef enum logic [1:0] {
    DIR_LEFT,
    DIR_RIGHT,
    DIR_UP,
    DIR_DOWN
  } scroll_dir_t;

  typedef struct packed {
    logic [2:0]  row;
    logic [47:0] pixels;
    logic        last;
    logic        bad;
  } marquee_row_t;

endpackage

// ===== verif/marquee_frame_checker.sv =====
// Watches both streams of the marquee scroller, predicts every row transaction and compares.
`timescale 1ns / 1ps
module marquee_frame_checker import lmq_pkg::*; import marquee_tb_pkg::*; #(
  parameter int MAX_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // slot[2:0], char_code[9:3], direction[11:10], zero pad
  input  logic        in_tuser,   // opcode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // row_index[2:0], row_pixels[50:3], zero pad
  input  logic        out_tlast,  // last_row
  input  logic        out_tuser,  // bad_char
  output int          rows_outstanding,
  output int          mismatch_count
);

  logic [OUT_PIX_W-1:0] board_rows [GLYPH_ROWS];
  logic [3:0]           msg_len;
  marquee_row_t         pending_rows [$];
  int                   errors = 0;

  // Font art, rows top to bottom; within a row the leftmost digit is board column 0.
  function automatic logic [4:0] glyph_art(input int g, input int r);
    logic [24:0] art;
    case (g)
      0:       art = {5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00000};
      1:       art = {5'b00110, 5'b00110, 5'b00110, 5'b00000, 5'b00110};
      2:       art = {5'b00100, 5'b01010, 5'b11111, 5'b10001, 5'b10001};
      3:       art = {5'b11111, 5'b10001, 5'b11111, 5'b10001, 5'b11111};
      4:       art = {5'b11111, 5'b10000, 5'b10000, 5'b10000, 5'b11111};
      5:       art = {5'b11110, 5'b10001, 5'b10001, 5'b10001, 5'b11110};
      6:       art = {5'b11111, 5'b10000, 5'b11111, 5'b10000, 5'b11111};
      7:       art = {5'b11111, 5'b10000, 5'b11111, 5'b10000, 5'b10000};
      8:       art = {5'b11111, 5'b10000, 5'b10111, 5'b10001, 5'b11111};
      9:       art = {5'b10001, 5'b10001, 5'b11111, 5'b10001, 5'b10001};
      10:      art = {5'b11111, 5'b00100, 5'b00100, 5'b00100, 5'b11111};
      11:      art = {5'b11111, 5'b00100, 5'b00100, 5'b00100, 5'b11100};
      12:      art = {5'b10001, 5'b10010, 5'b11100, 5'b10010, 5'b10001};
      13:      art = {5'b10000, 5'b10000, 5'b10000, 5'b10000, 5'b11111};
      14:      art = {5'b10001, 5'b11011, 5'b10101, 5'b10001, 5'b10001};
      15:      art = {5'b10001, 5'b11001, 5'b10101, 5'b10011, 5'b10001};
      16:      art = {5'b11111, 5'b10001, 5'b10001, 5'b10001, 5'b11111};
      17:      art = {5'b11111, 5'b10001, 5'b11111, 5'b10000, 5'b10000};
      18:      art = {5'b11111, 5'b10001, 5'b10101, 5'b11111, 5'b00010};
      19:      art = {5'b11111, 5'b10001, 5'b11111, 5'b10010, 5'b10001};
      20:      art = {5'b11111, 5'b10000, 5'b11111, 5'b00001, 5'b11111};
      21:      art = {5'b11111, 5'b00100, 5'b00100, 5'b00100, 5'b00100};
      22:      art = {5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b11111};
      23:      art = {5'b10001, 5'b10001, 5'b01010, 5'b01010, 5'b00100};
      24:      art = {5'b10001, 5'b10001, 5'b10101, 5'b11011, 5'b10001};
      25:      art = {5'b10001, 5'b01010, 5'b00100, 5'b01010, 5'b10001};
      26:      art = {5'b10001, 5'b01010, 5'b00100, 5'b00100, 5'b00100};
      27:      art = {5'b11111, 5'b00010, 5'b00100, 5'b01000, 5'b11111};
      default: art = '0;
    endcase
    return art[24-5*r -: 5];
  endfunction

  // Returns -1 for a character that has no glyph.
  function automatic int glyph_of(input logic [6:0] ch);
    int code;
    code = int'(ch);
    if (code == 32) return 0;
    if (code == 33) return 1;
    if (code >= 65 && code <= 90) return code - 65 + 2;
    if (code >= 97 && code <= 122) return code - 97 + 2;
    return -1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (errors < 100)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic apply_command(input marquee_op_t op, input logic [2:0] slot,
                               input logic [6:0] ch, input scroll_dir_t dir);
    int                   g, w, eff_len, sh;
    logic [63:0]          mask64;
    logic [OUT_PIX_W-1:0] mask, low, moved;
    logic [OUT_PIX_W-1:0] old_rows [GLYPH_ROWS];
    logic [4:0]           art;
    logic [5:0]           cells;
    marquee_row_t         res;
    eff_len = (msg_len == 0) ? 1 : (msg_len > MAX_CHARS) ? MAX_CHARS : int'(msg_len);
    w = eff_len * GLYPH_COLS;
    mask64 = (64'd1 << w) - 64'd1;
    mask = mask64[OUT_PIX_W-1:0];
    if (op == OP_LOAD) begin
      g = glyph_of(ch);
      if (g >= 0 && int'(slot) < MAX_CHARS) begin
        sh = int'(slot) * GLYPH_COLS;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          art = glyph_art(g, r);
          cells = '0;
          for (int c = 0; c < 5; c++) cells[c] = art[4-c];
          board_rows[r][sh +: 6] = cells;
        end
      end
      res.row = '0;
      res.pixels = '0;
      res.last = 1'b1;
      res.bad = (g < 0);
      pending_rows.push_back(res);
    end else begin
      if (dir == DIR_LEFT || dir == DIR_RIGHT) begin
        // Only the columns inside the wrap width rotate; the rest keep their bits.
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          low = board_rows[r] & mask;
          if (dir == DIR_LEFT)
            moved = (low >> 1) | ({{(OUT_PIX_W-1){1'b0}}, low[0]} << (w - 1));
          else
            moved = ((low << 1) & mask) | ((low >> (w - 1)) & {{(OUT_PIX_W-1){1'b0}}, 1'b1});
          board_rows[r] = (board_rows[r] & ~mask) | moved;
        end
      end else begin
        for (int r = 0; r < GLYPH_ROWS; r++) old_rows[r] = board_rows[r];
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          if (dir == DIR_UP)
            board_rows[r] = old_rows[(r + 1) % GLYPH_ROWS];
          else
            board_rows[r] = old_rows[(r + GLYPH_ROWS - 1) % GLYPH_ROWS];
        end
      end
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        res.row = 3'(r);
        res.pixels = board_rows[r] & mask;
        res.last = (r == GLYPH_ROWS - 1);
        res.bad = 1'b0;
        pending_rows.push_back(res);
      end
    end
  endtask

  always @(posedge clk) begin
    marquee_row_t want;
    if (!rst_n) begin
      for (int r = 0; r < GLYPH_ROWS; r++) board_rows[r] = '0;
      msg_len = 4'd8;
      pending_rows.delete();
    end else begin
      if (cfg_wr_en) msg_len = cfg_wr_data;
      if (in_tvalid && in_tready)
        apply_command(marquee_op_t'(in_tuser), in_tdata[2:0], in_tdata[9:3],
                      scroll_dir_t'(in_tdata[11:10]));
      if (out_tvalid && out_tready) begin
        if (pending_rows.size() == 0) begin
          flag_mismatch("unexpected result transaction", 64'(out_tdata), 64'd0);
        end else begin
          want = pending_rows.pop_front();
          if (out_tdata[2:0] !== want.row)
            flag_mismatch("row_index", 64'(out_tdata[2:0]), 64'(want.row));
          if (out_tdata[50:3] !== want.pixels)
            flag_mismatch("row_pixels", 64'(out_tdata[50:3]), 64'(want.pixels));
          if (out_tlast !== want.last)
            flag_mismatch("last_row", 64'(out_tlast), 64'(want.last));
          if (out_tuser !== want.bad)
            flag_mismatch("bad_char", 64'(out_tuser), 64'(want.bad));
        end
      end
    end
    rows_outstanding <= pending_rows.size();
    mismatch_count <= errors;
  end

endmodule

// ===== verif/tb.sv =====
// Top of the marquee scroller testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb;
  import marquee_tb_pkg::*;

  localparam int MAX_CHARS   = 8;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  int   rows_outstanding;
  int   mismatch_count;
  int   send_gap_pct = 0;
  int   recv_gap_pct = 0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int   hold_count = 0;
  int   cycle_count = 0;

  always #5 clk = ~clk;

  led_marquee_scroller #(.MAX_CHARS(MAX_CHARS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  marquee_frame_checker #(.MAX_CHARS(MAX_CHARS)) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .out_tuser       (out_tuser),
    .rows_outstanding(rows_outstanding),
    .mismatch_count  (mismatch_count)
  );

  // The receiver owns the long hold-off once it has been requested.
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      out_tready <= 1'b0;
      hold_count++;
      if (hold_count >= LONG_HOLD) hold_done = 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_cmd(input marquee_op_t op, input logic [2:0] slot,
                          input logic [6:0] ch, input scroll_dir_t dir);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0000, dir, ch, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic load_glyph(input logic [2:0] slot, input logic [6:0] ch);
    send_cmd(OP_LOAD, slot, ch, scroll_dir_t'($urandom_range(3)));
  endtask

  task automatic scroll(input scroll_dir_t dir);
    send_cmd(OP_SHIFT, 3'($urandom_range(7)), 7'($urandom_range(127)), dir);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rows_outstanding != 0) @(posedge clk);
  endtask

  // Every command returns at least one transaction, so a drained queue means an idle block.
  task automatic set_length(input logic [3:0] len);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [3:0] pick_length();
    case ($urandom_range(5))
      0:       return 4'd1;
      1:       return 4'd8;
      2:       return 4'd0;
      3:       return 4'd15;
      default: return 4'($urandom_range(7, 2));
    endcase
  endfunction

  function automatic logic [6:0] pick_char();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return 7'd32;
    if (sel < 10) return 7'd33;
    if (sel < 50) return 7'(65 + $urandom_range(25));
    if (sel < 85) return 7'(97 + $urandom_range(25));
    return 7'($urandom_range(127));
  endfunction

  // A message of MAX_CHARS loads into random slots, then scrolling with a few stray loads mixed in.
  task automatic run_segment(input int ops, input logic long_hold);
    set_length(pick_length());
    for (int s = 0; s < MAX_CHARS; s++) load_glyph(3'($urandom_range(7)), pick_char());
    if (long_hold) hold_request = 1'b1;
    for (int i = 0; i < ops; i++) begin
      if ($urandom_range(99) < 20)
        load_glyph(3'($urandom_range(7)), pick_char());
      else
        scroll(scroll_dir_t'($urandom_range(3)));
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_LOAD;
    send_gap_pct = 8;
    recv_gap_pct = 54;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Letters of both cases, space and the exclamation mark at both ends of the board.
    load_glyph(3'd0, 7'd65);
    load_glyph(3'd7, 7'd90);
    load_glyph(3'd3, 7'd97);
    load_glyph(3'd4, 7'd122);
    load_glyph(3'd1, 7'd32);
    load_glyph(3'd2, 7'd33);
    // Characters outside the font ranges must leave the board alone; M and q then load slots 5 and 6.
    load_glyph(3'd5, 7'd0);
    load_glyph(3'd6, 7'd127);
    load_glyph(3'd5, 7'd64);
    load_glyph(3'd6, 7'd91);
    load_glyph(3'd5, 7'd96);
    load_glyph(3'd6, 7'd123);
    load_glyph(3'd5, 7'd77);
    load_glyph(3'd6, 7'd113);
    scroll(DIR_LEFT);
    scroll(DIR_RIGHT);
    scroll(DIR_UP);
    scroll(DIR_DOWN);
    scroll(DIR_LEFT);
    // A narrow wrap leaves the columns beyond it to be seen again once widened.
    set_length(4'd1);
    scroll(DIR_LEFT);
    scroll(DIR_RIGHT);
    scroll(DIR_UP);
    set_length(4'd0);
    scroll(DIR_RIGHT);
    scroll(DIR_DOWN);
    set_length(4'd15);
    scroll(DIR_LEFT);
    scroll(DIR_UP);

    for (int seg = 0; seg < 3; seg++) run_segment(19, seg == 1);

    wait_drained();
    send_gap_pct = 54;
    recv_gap_pct = 8;
    for (int seg = 0; seg < 3; seg++) run_segment(19, 1'b0);

    wait_drained();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    for (int seg = 0; seg < 3; seg++) run_segment(19, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
